// File: rtl/core/b64e_pkg.sv
// b64e_pkg: shared types, character constants and the symbol table function
// for the base64 line-wrapping encoder. No dependencies.

package b64e_pkg;

    localparam int unsigned   MAX_LINE_LENGTH   = 1023;
    localparam logic [9:0]    LINE_LENGTH_RESET = 10'd76;
    // effective line-length ceiling in column width
    localparam logic [9:0]    LINE_LENGTH_CAP   =
        (MAX_LINE_LENGTH >= 1023) ? 10'd1023 : 10'(MAX_LINE_LENGTH);

    localparam logic [7:0]    CHAR_PLUS    = 8'h2B;
    localparam logic [7:0]    CHAR_SLASH   = 8'h2F;
    localparam logic [7:0]    CHAR_PAD     = 8'h3D;
    localparam logic [7:0]    CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0]    CHAR_UPPER_A = 8'h41;
    localparam logic [7:0]    CHAR_LOWER_A = 8'h61;
    localparam logic [7:0]    CHAR_DIGIT_0 = 8'h30;

    // one complete or flushed group handed from front to back
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  nbytes;
        logic        last;
    } t_group;

    function automatic logic [7:0] symbol_of(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = CHAR_UPPER_A + {2'b00, v};
        end else if (v < 6'd52) begin
            c = CHAR_LOWER_A + {2'b00, v - 6'd26};
        end else if (v < 6'd62) begin
            c = CHAR_DIGIT_0 + {2'b00, v - 6'd52};
        end else if (v == 6'd62) begin
            c = CHAR_PLUS;
        end else begin
            c = CHAR_SLASH;
        end
        return c;
    endfunction

endpackage

// File: rtl/core/b64e_front.sv
// b64e_front: accepts input bytes, gathers groups of three and pushes
// complete or flushed groups into the queue. Depends on b64e_pkg.

module b64e_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [7:0]           i_s_tdata,   // [7:0] data_byte
    input  logic                 i_s_tlast,   // last_byte
    input  logic                 i_q_full,
    output logic                 o_push,
    output b64e_pkg::t_group     o_grp
);
    import b64e_pkg::*;

    logic [15:0] r_held, n_held;
    logic [1:0]  r_count, n_count;
    logic [1:0]  nbytes;
    logic        accept;

    assign o_s_tready = !i_q_full;
    assign accept     = i_s_tvalid && !i_q_full;
    assign nbytes     = (r_count == 2'd3) ? 2'd3 : r_count + 2'd1;

    always_comb begin
        n_held      = r_held;
        n_count     = r_count;
        o_push      = 1'b0;
        o_grp.last  = i_s_tlast;
        o_grp.nbytes = nbytes;
        case (nbytes)
            2'd1:    o_grp.word = {i_s_tdata, 16'h0000};
            2'd2:    o_grp.word = {r_held[7:0], i_s_tdata, 8'h00};
            default: o_grp.word = {r_held, i_s_tdata};
        endcase
        if (accept) begin
            if (nbytes != 2'd3 && !i_s_tlast) begin
                n_held  = {r_held[7:0], i_s_tdata};
                n_count = nbytes;
            end else begin
                o_push  = 1'b1;
                n_held  = '0;
                n_count = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= '0;
            r_count <= 2'd0;
        end else begin
            r_held  <= n_held;
            r_count <= n_count;
        end
    end

endmodule

// File: rtl/core/b64e_queue.sv
// b64e_queue: two-entry group queue between front and back so that each
// side stalls on its own. Depends on b64e_pkg.

module b64e_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  b64e_pkg::t_group     i_grp,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_valid,
    output b64e_pkg::t_group     o_grp
);
    import b64e_pkg::*;

    t_group     r_mem [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_fill, n_fill;

    assign o_full  = (r_fill == 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_grp   = r_mem[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_fill = r_fill;
        if (i_push) begin
            n_wptr = !r_wptr;
        end
        if (i_pop) begin
            n_rptr = !r_rptr;
        end
        case ({i_push, i_pop})
            2'b10:   n_fill = r_fill + 2'd1;
            2'b01:   n_fill = r_fill - 2'd1;
            default: n_fill = r_fill;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_grp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_fill <= n_fill;
        end
    end

endmodule

// File: rtl/core/b64e_back.sv
// b64e_back: turns queued groups into characters one per cycle unless stalled,
// inserts newlines by line column and drives the output register. Depends on b64e_pkg.

module b64e_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [9:0]           i_line_length,
    input  logic                 i_grp_valid,
    input  b64e_pkg::t_group     i_grp,
    output logic                 o_pop,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [7:0]           o_m_tdata,   // [7:0] out_char
    output logic                 o_m_tlast,   // run_last
    output logic                 o_m_tuser    // [0] message_end
);
    import b64e_pkg::*;

    logic [1:0] r_k, n_k;
    logic       r_nl_pend, n_nl_pend;
    logic [9:0] r_col, n_col;
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_char, n_out_char;
    logic       r_out_last, n_out_last;
    logic       r_out_end, n_out_end;

    logic [9:0] limit;
    logic [9:0] col_inc;
    logic       nl;
    logic [5:0] sextet;
    logic [7:0] sym;
    logic       advance;

    assign limit   = (i_line_length > LINE_LENGTH_CAP) ? LINE_LENGTH_CAP : i_line_length;
    assign col_inc = r_col + 10'd1;
    assign nl      = (limit != 10'd0) && (col_inc >= limit);
    assign advance = i_grp_valid && (!r_out_valid || i_m_tready);

    always_comb begin
        case (r_k)
            2'd0:    sextet = i_grp.word[23:18];
            2'd1:    sextet = i_grp.word[17:12];
            2'd2:    sextet = i_grp.word[11:6];
            default: sextet = i_grp.word[5:0];
        endcase
        sym = symbol_of(sextet);
        // zero-filled tail of a short group becomes pad
        if ((r_k == 2'd3 && i_grp.nbytes != 2'd3) || (r_k == 2'd2 && i_grp.nbytes == 2'd1)) begin
            sym = CHAR_PAD;
        end
    end

    always_comb begin
        n_k         = r_k;
        n_nl_pend   = r_nl_pend;
        n_col       = r_col;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        n_out_end   = r_out_end;
        o_pop       = 1'b0;
        if (advance) begin
            n_out_valid = 1'b1;
            if (r_nl_pend) begin
                n_out_char = CHAR_NEWLINE;
                n_nl_pend  = 1'b0;
                n_out_last = (r_k == 2'd3);
                n_out_end  = 1'b0;
                if (r_k == 2'd3) begin
                    o_pop = 1'b1;
                    n_k   = 2'd0;
                end else begin
                    n_k = r_k + 2'd1;
                end
            end else begin
                n_out_char = sym;
                n_col      = nl ? 10'd0 : col_inc;
                // newline after the message's final character is dropped
                if (nl && !(r_k == 2'd3 && i_grp.last)) begin
                    n_nl_pend  = 1'b1;
                    n_out_last = 1'b0;
                    n_out_end  = 1'b0;
                end else begin
                    n_out_last = (r_k == 2'd3);
                    n_out_end  = (r_k == 2'd3) && i_grp.last;
                    if (r_k == 2'd3) begin
                        o_pop = 1'b1;
                        n_k   = 2'd0;
                        if (i_grp.last) begin
                            n_col = 10'd0;
                        end
                    end else begin
                        n_k = r_k + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= 2'd0;
            r_nl_pend   <= 1'b0;
            r_col       <= 10'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_k         <= n_k;
            r_nl_pend   <= n_nl_pend;
            r_col       <= n_col;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
        r_out_end  <= n_out_end;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_char;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_end;

endmodule

// File: rtl/core/base64_line_wrapping_encoder.sv
// base64_line_wrapping_encoder: top level, holds the line-length register and
// joins front, queue and back. Depends on b64e_pkg, b64e_front, b64e_queue, b64e_back.
//
//  channel   direction   handshake                    payload
//  s         in          i_s_tvalid / o_s_tready      tdata=data_byte, tlast=last_byte
//  m         out         o_m_tvalid / i_m_tready      tdata=out_char, tlast=run_last,
//                                                     tuser=message_end
//  cfg       in          i_cfg_we                     i_cfg_wdata=line_length
//
// the back end emits one character per cycle from the output register while
// the receiver is ready and a group is queued; bytes that do not close a group
// are held by the front, which takes bytes as long as the two-entry group queue
// has room. synchronous active-low reset clears the queue, the byte holder and
// the column and sets line_length to 76.

module base64_line_wrapping_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,    // [7:0] data_byte
    input  logic        i_s_tlast,    // last_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,    // [7:0] out_char
    output logic        o_m_tlast,    // run_last
    output logic        o_m_tuser,    // [0] message_end
    input  logic        i_cfg_we,
    input  logic [9:0]  i_cfg_wdata   // [9:0] line_length
);
    import b64e_pkg::*;

    logic [9:0] r_line_length;
    logic       q_full, q_push, q_pop, q_valid;
    t_group     front_grp, head_grp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_length <= LINE_LENGTH_RESET;
        end else if (i_cfg_we) begin
            r_line_length <= i_cfg_wdata;
        end
    end

    b64e_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_grp      (front_grp)
    );

    b64e_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_grp   (front_grp),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_grp   (head_grp)
    );

    b64e_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_line_length (r_line_length),
        .i_grp_valid   (q_valid),
        .i_grp         (head_grp),
        .o_pop         (q_pop),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tlast     (o_m_tlast),
        .o_m_tuser     (o_m_tuser)
    );

endmodule

// File: tb/sv/base64_line_wrapping_encoder_checker.sv
// base64_line_wrapping_encoder_checker: watches the byte, character and config channels,
// predicts every output character from the accepted bytes and compares in order.
// Depends on b64e_pkg for the character constants and the line-length cap.
`timescale 1ns / 100ps

module base64_line_wrapping_encoder_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,
    input  logic        i_m_tlast,
    input  logic        i_m_tuser,
    input  logic        i_cfg_we,
    input  logic [9:0]  i_cfg_wdata,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);
    import b64e_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       run_last;
        logic       msg_end;
    } t_enc_char;

    t_enc_char   char_q[$];
    logic [9:0]  line_len;
    logic [15:0] held;
    logic [1:0]  held_cnt;
    logic [9:0]  column;

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        if (v < 6'd26) return CHAR_UPPER_A + 8'(v);
        if (v < 6'd52) return CHAR_LOWER_A + 8'(v) - 8'd26;
        if (v < 6'd62) return CHAR_DIGIT_0 + 8'(v) - 8'd52;
        return (v == 6'd62) ? CHAR_PLUS : CHAR_SLASH;
    endfunction

    task automatic encode_byte(input logic [7:0] b, input logic fin);
        logic [23:0] grp;
        logic [7:0]  chars [8];
        logic [9:0]  lim;
        logic [7:0]  c;
        t_enc_char   e;
        int          cnt;
        int          n_bytes;
        cnt = 0;
        n_bytes = int'(held_cnt) + 1;
        if (n_bytes > 3) n_bytes = 3;
        // partial group and not the end of the message: just hold the byte
        if (n_bytes < 3 && !fin) begin
            held = {held[7:0], b};
            held_cnt = 2'(n_bytes);
            return;
        end
        case (n_bytes)
            1:       grp = {b, 16'h0000};
            2:       grp = {held[7:0], b, 8'h00};
            default: grp = {held, b};
        endcase
        lim = (line_len > LINE_LENGTH_CAP) ? LINE_LENGTH_CAP : line_len;
        for (int k = 0; k < 4; k++) begin
            c = sextet_char(grp[23 - 6 * k -: 6]);
            if ((k == 3 && n_bytes < 3) || (k == 2 && n_bytes < 2)) c = CHAR_PAD;
            chars[cnt] = c;
            cnt++;
            column = column + 10'd1;
            // at or past the line length, also when the length was lowered mid-message
            if (lim != 10'd0 && column >= lim) begin
                column = 10'd0;
                chars[cnt] = CHAR_NEWLINE;
                cnt++;
            end
        end
        // no newline after the final character of a message
        if (fin && chars[cnt - 1] == CHAR_NEWLINE) cnt--;
        for (int i = 0; i < cnt; i++) begin
            e.ch       = chars[i];
            e.run_last = (i == cnt - 1);
            e.msg_end  = (i == cnt - 1) && fin;
            char_q.push_back(e);
        end
        held = 16'h0000;
        held_cnt = 2'd0;
        if (fin) column = 10'd0;
    endtask

    task automatic report_fault(input string what);
        o_fail_count++;
        if (o_fail_count <= 10) $display("[%0t] mismatch: %s", $time, what);
    endtask

    always @(posedge i_clk) begin
        t_enc_char want;
        if (!i_rst_n) begin
            line_len = LINE_LENGTH_RESET;
            held     = 16'h0000;
            held_cnt = 2'd0;
            column   = 10'd0;
            char_q.delete();
        end else begin
            if (i_cfg_we) line_len = i_cfg_wdata;
            if (i_s_tvalid && i_s_tready) encode_byte(i_s_tdata, i_s_tlast);
            if (i_m_tvalid && i_m_tready) begin
                if (char_q.size() == 0) begin
                    report_fault($sformatf("unexpected char %02h run_last %0b message_end %0b",
                        i_m_tdata, i_m_tlast, i_m_tuser));
                end else begin
                    want = char_q.pop_front();
                    o_checked++;
                    if (want.ch !== i_m_tdata || want.run_last !== i_m_tlast
                            || want.msg_end !== i_m_tuser) begin
                        report_fault($sformatf(
                            "char exp %02h got %02h, last exp %0b got %0b, end exp %0b got %0b",
                            want.ch, i_m_tdata, want.run_last, i_m_tlast,
                            want.msg_end, i_m_tuser));
                    end
                end
            end
        end
        o_pending = char_q.size();
    end

endmodule

// File: tb/sv/base64_line_wrapping_encoder_tb.sv
// base64_line_wrapping_encoder_tb: drives byte messages and line-length writes into the
// encoder with random pacing on both sides; depends on b64e_pkg, the RTL and the checker.
`timescale 1ns / 100ps

module base64_line_wrapping_encoder_tb;
    import b64e_pkg::*;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_s_tvalid  = 1'b0;
    logic [7:0] i_s_tdata   = 8'h00;
    logic       i_s_tlast   = 1'b0;
    logic       i_m_tready  = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [9:0] i_cfg_wdata = 10'd0;
    logic       o_s_tready;
    logic       o_m_tvalid;
    logic [7:0] o_m_tdata;
    logic       o_m_tlast;
    logic       o_m_tuser;

    int fail_count;
    int chars_pending;
    int chars_checked;
    int bytes_sent    = 0;
    int msgs_sent     = 0;
    int len_writes    = 0;
    bit sender_idle   = 1'b0;
    bit sink_idle     = 1'b0;

    base64_line_wrapping_encoder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    base64_line_wrapping_encoder_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tlast    (i_s_tlast),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tlast    (o_m_tlast),
        .i_m_tuser    (o_m_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (chars_pending),
        .o_checked    (chars_checked)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("timeout: encoder stopped making progress");
        $display("Verification failed");
        $finish;
    end

    // receiver side: ready drops in random bursts while sink_idle is set
    initial begin
        forever begin
            @(negedge i_clk);
            if (sink_idle && $urandom_range(0, 5) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(0, 16)) @(negedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the request is taken
    task automatic send_byte(input logic [7:0] b, input logic fin);
        if (sender_idle && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= fin;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
        bytes_sent++;
        if (fin) msgs_sent++;
    endtask

    task automatic send_random_bytes(input int n, input bit fin);
        for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)), fin && (i == n - 1));
    endtask

    // only written with the encoder drained; held bytes make no output, so allow a margin
    task automatic set_line_length(input logic [9:0] len);
        i_s_tvalid <= 1'b0;
        wait (chars_pending == 0);
        @(negedge i_clk);
        repeat (12) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= len;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        len_writes++;
    endtask

    function automatic logic [9:0] pick_line_length();
        case ($urandom_range(0, 7))
            0:       return 10'd0;
            1:       return 10'd1;
            2:       return 10'd1023;
            3:       return LINE_LENGTH_RESET;
            4:       return 10'($urandom_range(2, 8));
            5:       return 10'($urandom_range(0, 1023));
            default: return 10'($urandom_range(1, 40));
        endcase
    endfunction

    initial begin
        int msg_len;
        int split_at;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // one, two and three byte messages at the reset line length
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFB, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hFF, 1'b1);
        // newline after a full line, dropped at the message end
        set_line_length(10'd4);
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h6E, 1'b0);
        send_byte(8'h00, 1'b1);
        set_line_length(10'd1);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b1);
        // shorten the line while the column is already past it
        set_line_length(LINE_LENGTH_RESET);
        send_random_bytes(6, 1'b0);
        set_line_length(10'd3);
        send_byte(8'h55, 1'b1);
        set_line_length(10'd0);
        send_random_bytes(4, 1'b1);
        set_line_length(10'd1023);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b1);

        while (bytes_sent < 460) begin
            if (bytes_sent >= 380) begin
                sender_idle = 1'b0;
                sink_idle   = 1'b0;
            end else begin
                sender_idle = ($urandom_range(0, 3) != 0);
                sink_idle   = ($urandom_range(0, 3) != 0);
            end
            set_line_length(pick_line_length());
            repeat ($urandom_range(2, 6)) begin
                if (bytes_sent < 460) begin
                    msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60)
                                                          : $urandom_range(1, 12);
                    if (msg_len > 1 && $urandom_range(0, 5) == 0) begin
                        // change the line length in the middle of a message
                        split_at = $urandom_range(1, msg_len - 1);
                        send_random_bytes(split_at, 1'b0);
                        set_line_length(pick_line_length());
                        send_random_bytes(msg_len - split_at, 1'b1);
                    end else begin
                        send_random_bytes(msg_len, 1'b1);
                    end
                end
            end
        end

        i_s_tvalid <= 1'b0;
        wait (chars_pending == 0);
        repeat (20) @(negedge i_clk);
        $display("run covered %0d messages, %0d bytes and %0d line-length writes",
            msgs_sent, bytes_sent, len_writes);
        $display("%0d output characters compared, %0d mismatches", chars_checked, fail_count);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
